>>> design/mlfq_pkg.sv
// Package: sizes, command codes, slot entry type and fixed-point helpers.
package mlfq_pkg;

   localparam int SLOTS     = 64;
   localparam int FRAC_BITS = 16;
   localparam int SLOT_W    = $clog2(SLOTS);

   localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] C59_FX = (64'sd59 * ONE_FX) / 64'sd60;
   localparam logic signed [63:0] C1_FX  = ONE_FX / 64'sd60;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = FRAC_BITS + 2;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // divider for the recent cpu decay factor
   localparam int DIV_NUM_W = 33 + FRAC_BITS;
   localparam int DIV_DEN_W = 34;
   localparam int DIV_REM_W = DIV_DEN_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
   localparam int FRAC_W    = FRAC_BITS + 1;

   localparam int RC_X100_MAX = 3276800;
   localparam int LA_X100_MAX = 6500;

   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_SET_NICE = 3'd1;
   localparam logic [2:0] CMD_CREATE   = 3'd2;
   localparam logic [2:0] CMD_EXIT     = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;

   localparam logic CSR_MLFQ_ENABLE = 1'b0;
   localparam logic CSR_TICKS_PER_S = 1'b1;

   typedef struct packed {
      logic signed [5:0]  nice;
      logic signed [31:0] rc;
      logic [5:0]         pri;
   } slot_entry_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

   // divide by one in fixed point, rounding toward zero
   function automatic logic signed [63:0] fx_trunc(input logic signed [PROD_W-1:0] p);
      logic signed [63:0] x;
      x = 64'(p);
      if (x < 0)
         x = x + ONE_FX - 64'sd1;
      return x >>> FRAC_BITS;
   endfunction

   function automatic logic [5:0] calc_priority(input logic signed [31:0] rc,
                                                input logic signed [5:0] nice);
      logic signed [47:0] q4;
      logic signed [47:0] v;
      logic signed [47:0] p;
      logic [5:0]         r;
      q4 = 48'(rc);
      if (q4 < 0)
         q4 = q4 + 48'sd3;
      q4 = q4 >>> 2;
      v = (48'sd63 <<< FRAC_BITS) - q4 - ((48'(nice) * 48'sd2) <<< FRAC_BITS);
      if (v < 0)
         v = v + (48'sd1 <<< FRAC_BITS) - 48'sd1;
      p = v >>> FRAC_BITS;
      if (p < 0)
         r = 6'd0;
      else if (p > 48'sd63)
         r = 6'd63;
      else
         r = p[5:0];
      return r;
   endfunction

endpackage

>>> design/mlfq_div.sv
// Restoring divider, one quotient bit per cycle, for the decay factor.
module mlfq_div
   import mlfq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] numer,
   input  logic [DIV_DEN_W-1:0] denom,
   output logic                 done,
   output logic [FRAC_W-1:0]    quot
);

   logic [DIV_NUM_W-1:0] num_ff,  num_in;
   logic [DIV_DEN_W-1:0] den_ff,  den_in;
   logic [DIV_REM_W-1:0] rem_ff,  rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_REM_W-1:0] rem_sh;
   logic                 fits;

   always_comb begin
      rem_sh  = {rem_ff[DIV_REM_W-2:0], num_ff[DIV_NUM_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         num_in = {num_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff[FRAC_W-1:0];

endmodule

>>> design/mlfq_priority_update_engine.sv
// Top level: MLFQ slot table, load average and the sequencer around one shared multiplier.
// A once-a-second tick adds a load average update, a divider run and a sweep of all 64 slots;
// a fourth tick sweeps the 64 slots alone.
// One item at a time: the slot table has one read and one write port and the multiplier is shared.
// Reset clears the valid bits, the load average and the tick phases; slot data needs no clearing.
module mlfq_priority_update_engine
   import mlfq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [5:0]         req_slot,
   input  logic [5:0]         req_running_slot,
   input  logic               req_running_is_idle,
   input  logic [6:0]         req_ready_count,
   input  logic signed [5:0]  req_nice_value,
   input  logic [5:0]         req_start_priority,
   input  logic               req_inherit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_priority_res,
   output logic signed [5:0]  rsp_nice,
   output logic signed [22:0] rsp_recent_cpu_x100,
   output logic [12:0]        rsp_load_avg_x100,
   output logic               rsp_priorities_recomputed,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [9:0]         csr_wdata
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CHG_RD  = 5'd1;
   localparam logic [4:0] S_CHG_WR  = 5'd2;
   localparam logic [4:0] S_LA_MUL  = 5'd3;
   localparam logic [4:0] S_LA_ADD  = 5'd4;
   localparam logic [4:0] S_DIV_GO  = 5'd5;
   localparam logic [4:0] S_DIV_WT  = 5'd6;
   localparam logic [4:0] S_SW_RD   = 5'd7;
   localparam logic [4:0] S_SW_MUL  = 5'd8;
   localparam logic [4:0] S_SW_UPD  = 5'd9;
   localparam logic [4:0] S_SW_WR   = 5'd10;
   localparam logic [4:0] S_NICE_RD = 5'd11;
   localparam logic [4:0] S_NICE_WR = 5'd12;
   localparam logic [4:0] S_CRT_RD  = 5'd13;
   localparam logic [4:0] S_CRT_WR  = 5'd14;
   localparam logic [4:0] S_REP_RD  = 5'd15;
   localparam logic [4:0] S_REP_M1  = 5'd16;
   localparam logic [4:0] S_REP_M2  = 5'd17;
   localparam logic [4:0] S_REP_OUT = 5'd18;

   // configuration
   logic       enable_ff;
   logic [9:0] tps_ff;

   // sequencer and per-item context
   logic [4:0]        state_ff, state_in;
   logic [5:0]        slot_ff;
   logic [5:0]        run_ff;
   logic              inherit_ff;
   logic [5:0]        startp_ff;
   logic signed [5:0] nv_ff;
   logic [8:0]        n_ff;
   logic              sec_ff;
   logic              quad_ff;
   logic              recomp_ff;
   logic [5:0]        rep_slot_ff;
   logic              rep_use_ff;
   logic [SLOT_W-1:0] idx_ff;

   // scheduler state
   logic [SLOTS-1:0]   valid_ff;
   logic signed [31:0] la_ff;
   logic [9:0]         sphase_ff;
   logic [1:0]         qphase_ff;
   logic [FRAC_W-1:0]  frac_ff;
   logic signed [31:0] rc_new_ff;

   // slot table
   slot_entry_type    mem [SLOTS];
   slot_entry_type    rd_ff;
   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   slot_entry_type    wr_data;

   // shared multiplier
   logic                      mul_en;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p_ff;

   // divider
   logic                 div_start;
   logic                 div_done;
   logic [FRAC_W-1:0]    div_quot;
   logic [32:0]          two_la;

   // report
   logic signed [22:0] rc_x100_ff;
   logic [PROD_W-1:0]  round_v;
   logic [12:0]        la_x100;
   logic               rep_ok;
   logic               out_free;

   // request decode
   logic              req_xfer;
   logic              run_ok;
   logic              run_live;
   logic              slot_ok;
   logic signed [5:0] nv_sat;
   logic [8:0]        n_cnt;
   logic [9:0]        sphase_next;
   logic              sec_next;
   logic [1:0]        qphase_next;

   assign req_stall = state_ff != S_IDLE;
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid || !rsp_stall;

   always_comb begin
      run_ok   = !req_running_is_idle && ({1'b0, req_running_slot} < 7'(SLOTS));
      run_live = run_ok && valid_ff[req_running_slot[SLOT_W-1:0]];
      slot_ok  = {1'b0, req_slot} < 7'(SLOTS);
      if (req_nice_value > 6'sd20)
         nv_sat = 6'sd20;
      else if (req_nice_value < -6'sd20)
         nv_sat = -6'sd20;
      else
         nv_sat = req_nice_value;
      n_cnt = ({2'b0, req_ready_count} > 9'(SLOTS)) ? 9'(SLOTS) : {2'b0, req_ready_count};
      n_cnt = n_cnt + {8'b0, !req_running_is_idle};
      sphase_next = sphase_ff + 10'd1;
      sec_next    = sphase_next >= tps_ff;
      qphase_next = qphase_ff + 2'd1;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_cmd)
                  CMD_TICK: begin
                     if (!enable_ff)
                        state_in = S_REP_RD;
                     else if (run_live)
                        state_in = S_CHG_RD;
                     else if (sec_next)
                        state_in = S_LA_MUL;
                     else if (qphase_next == 2'd0)
                        state_in = S_SW_RD;
                     else
                        state_in = S_REP_RD;
                  end
                  CMD_SET_NICE: state_in = run_live ? S_NICE_RD : S_REP_RD;
                  CMD_CREATE: begin
                     if (!slot_ok)
                        state_in = S_REP_RD;
                     else if (req_inherit && run_live)
                        state_in = S_CRT_RD;
                     else
                        state_in = S_CRT_WR;
                  end
                  default: state_in = S_REP_RD;
               endcase
            end
         end
         S_CHG_RD: state_in = S_CHG_WR;
         S_CHG_WR: begin
            if (sec_ff)
               state_in = S_LA_MUL;
            else if (quad_ff)
               state_in = S_SW_RD;
            else
               state_in = S_REP_RD;
         end
         S_LA_MUL: state_in = S_LA_ADD;
         S_LA_ADD: state_in = S_DIV_GO;
         S_DIV_GO: state_in = S_DIV_WT;
         S_DIV_WT: state_in = div_done ? S_SW_RD : S_DIV_WT;
         S_SW_RD:  state_in = S_SW_MUL;
         S_SW_MUL: state_in = S_SW_UPD;
         S_SW_UPD: state_in = S_SW_WR;
         S_SW_WR:  state_in = (idx_ff == SLOT_W'(SLOTS - 1)) ? S_REP_RD : S_SW_RD;
         S_NICE_RD: state_in = S_NICE_WR;
         S_NICE_WR: state_in = S_REP_RD;
         S_CRT_RD:  state_in = S_CRT_WR;
         S_CRT_WR:  state_in = S_REP_RD;
         S_REP_RD:  state_in = S_REP_M1;
         S_REP_M1:  state_in = S_REP_M2;
         S_REP_M2:  state_in = S_REP_OUT;
         S_REP_OUT: state_in = out_free ? S_IDLE : S_REP_OUT;
         default:   state_in = S_IDLE;
      endcase
   end

   // table port selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = run_ff[SLOT_W-1:0];
      wr_en   = 1'b0;
      wr_addr = run_ff[SLOT_W-1:0];
      wr_data = rd_ff;
      unique case (state_ff)
         S_CHG_RD, S_NICE_RD, S_CRT_RD: rd_en = 1'b1;
         S_SW_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff;
         end
         S_REP_RD: begin
            rd_en   = 1'b1;
            rd_addr = rep_slot_ff[SLOT_W-1:0];
         end
         S_CHG_WR: begin
            wr_en      = 1'b1;
            wr_data.rc = sat32(64'(rd_ff.rc) + ONE_FX);
         end
         S_NICE_WR: begin
            wr_en        = 1'b1;
            wr_data.nice = nv_ff;
            wr_data.pri  = calc_priority(rd_ff.rc, nv_ff);
         end
         S_CRT_WR: begin
            wr_en   = 1'b1;
            wr_addr = slot_ff[SLOT_W-1:0];
            if (inherit_ff) begin
               wr_data.pri = calc_priority(rd_ff.rc, rd_ff.nice);
            end else begin
               wr_data.nice = '0;
               wr_data.rc   = '0;
               wr_data.pri  = startp_ff;
            end
         end
         S_SW_WR: begin
            wr_en      = valid_ff[idx_ff];
            wr_addr    = idx_ff;
            wr_data.rc = rc_new_ff;
            if (quad_ff)
               wr_data.pri = calc_priority(rc_new_ff, rd_ff.nice);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_ff <= mem[rd_addr];
   end

   // shared multiplier: decay, load average and both report scalings
   always_comb begin
      mul_en = 1'b1;
      mul_a  = MUL_A_W'(la_ff);
      mul_b  = MUL_B_W'(C59_FX);
      unique case (state_ff)
         S_LA_MUL: ;
         S_SW_MUL: begin
            mul_a = MUL_A_W'(rd_ff.rc);
            mul_b = MUL_B_W'({1'b0, frac_ff});
         end
         S_REP_M1: begin
            mul_a = (rd_ff.rc < 0) ? -MUL_A_W'(rd_ff.rc) : MUL_A_W'(rd_ff.rc);
            mul_b = MUL_B_W'(100);
         end
         S_REP_M2: mul_b = MUL_B_W'(100);
         default:  mul_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en)
         mul_p_ff <= PROD_W'(mul_a * mul_b);
   end

   assign two_la    = {la_ff, 1'b0};
   assign div_start = state_ff == S_DIV_GO;

   mlfq_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer ({two_la, FRAC_BITS'(0)}),
      .denom ({1'b0, two_la} + DIV_DEN_W'(ONE_FX)),
      .done  (div_done),
      .quot  (div_quot)
   );

   // round half away: add one half, drop the fraction
   assign round_v = mul_p_ff + PROD_W'(ONE_FX >>> 1);

   always_comb begin
      if ((round_v >> FRAC_BITS) > PROD_W'(LA_X100_MAX))
         la_x100 = 13'(LA_X100_MAX);
      else
         la_x100 = round_v[FRAC_BITS +: 13];
   end

   assign rep_ok = rep_use_ff && ({1'b0, rep_slot_ff} < 7'(SLOTS));

   // datapath and context registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         slot_ff    <= req_slot;
         run_ff     <= req_running_slot;
         // inherit only from a live parent, otherwise start from zero nice and recent cpu and the start priority
         inherit_ff <= req_inherit && run_live;
         startp_ff  <= req_start_priority;
         nv_ff      <= nv_sat;
         n_ff       <= n_cnt;
         if (req_cmd == CMD_CREATE || req_cmd == CMD_READ) begin
            rep_slot_ff <= req_slot;
            rep_use_ff  <= 1'b1;
         end else begin
            rep_slot_ff <= req_running_slot;
            rep_use_ff  <= run_ok;
         end
         if (req_cmd == CMD_TICK) begin
            sec_ff    <= sec_next;
            quad_ff   <= qphase_next == 2'd0;
            recomp_ff <= enable_ff && (qphase_next == 2'd0);
         end else begin
            sec_ff    <= 1'b0;
            quad_ff   <= 1'b0;
            recomp_ff <= 1'b0;
         end
      end
      if (state_ff == S_DIV_WT && div_done)
         frac_ff <= div_quot;
      if (state_ff == S_SW_UPD) begin
         if (sec_ff)
            rc_new_ff <= sat32(fx_trunc(mul_p_ff) + (64'(rd_ff.nice) <<< FRAC_BITS));
         else
            rc_new_ff <= rd_ff.rc;
      end
      // hold rc x100, with its sign restored, while the multiplier moves on to the load average
      if (state_ff == S_REP_M2) begin
         if ((round_v >> FRAC_BITS) > PROD_W'(RC_X100_MAX))
            rc_x100_ff <= (rd_ff.rc < 0) ? -23'sd3276800 : 23'sd3276800;
         else
            rc_x100_ff <= (rd_ff.rc < 0) ? -$signed(round_v[FRAC_BITS +: 23])
                                         : $signed(round_v[FRAC_BITS +: 23]);
      end
      if (state_ff == S_REP_OUT && out_free) begin
         rsp_priority_res          <= rep_ok ? rd_ff.pri  : 6'd0;
         rsp_nice                  <= rep_ok ? rd_ff.nice : 6'sd0;
         rsp_recent_cpu_x100       <= rep_ok ? rc_x100_ff : 23'sd0;
         rsp_load_avg_x100         <= la_x100;
         rsp_priorities_recomputed <= recomp_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
         valid_ff  <= '0;
         la_ff     <= '0;
         sphase_ff <= '0;
         qphase_ff <= '0;
         idx_ff    <= '0;
         enable_ff <= 1'b1;
         tps_ff    <= 10'd100;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MLFQ_ENABLE: enable_ff <= csr_wdata[0];
               CSR_TICKS_PER_S: tps_ff    <= csr_wdata;
               default: ;
            endcase
         end
         // advance the tick phases on every tick, enabled or not
         if (req_xfer && req_cmd == CMD_TICK) begin
            sphase_ff <= sec_next ? 10'd0 : sphase_next;
            qphase_ff <= qphase_next;
         end
         if (req_xfer && req_cmd == CMD_EXIT && slot_ok)
            valid_ff[req_slot[SLOT_W-1:0]] <= 1'b0;
         if (state_ff == S_CRT_WR)
            valid_ff[slot_ff[SLOT_W-1:0]] <= 1'b1;
         if (state_ff == S_LA_ADD)
            la_ff <= sat32(fx_trunc(mul_p_ff) + C1_FX * 64'(n_ff));
         if (state_ff == S_DIV_WT || state_ff == S_CHG_WR || state_ff == S_IDLE)
            idx_ff <= '0;
         else if (state_ff == S_SW_WR)
            idx_ff <= idx_ff + 1'b1;
         if (state_ff == S_REP_OUT && out_free)
            rsp_valid <= 1'b1;
         else if (!rsp_stall)
            rsp_valid <= 1'b0;
      end
   end

endmodule
